// ===== sv/http_method_name_matcher_core_defines.svh =====
// ----------------------------------------------------------------------------
// http method name matcher: assertion macros
// shared property wrappers on clk_i with the active-low reset as disable
// ----------------------------------------------------------------------------
`ifndef HTTP_METHOD_NAME_MATCHER_CORE_DEFINES_SVH
`define HTTP_METHOD_NAME_MATCHER_CORE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define HMNM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define HMNM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/hmnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hmnm_pkg
// types, constants and verb table of the http method name matcher
// ----------------------------------------------------------------------------
package hmnm_pkg;

  // longest name that can still match: "webdav_" plus "proppatch"
  localparam int unsigned KeepLen    = 16;
  localparam int unsigned VerbCount  = 18;
  localparam int unsigned VerbMaxLen = 9;
  localparam int unsigned LenW       = 5;
  localparam int unsigned CodeW      = 5;
  localparam int unsigned HttpPreLen = 5;
  localparam int unsigned DavPreLen  = 7;

  typedef enum logic [CodeW-1:0] {
    M_GET       = 5'd0,
    M_POST      = 5'd1,
    M_PUT       = 5'd2,
    M_PATCH     = 5'd3,
    M_PROPFIND  = 5'd4,
    M_PROPPATCH = 5'd5,
    M_OPTIONS   = 5'd6,
    M_HEAD      = 5'd7,
    M_DELETE    = 5'd8,
    M_TRACE     = 5'd9,
    M_CONNECT   = 5'd10,
    M_COPY      = 5'd11,
    M_LINK      = 5'd12,
    M_LOCK      = 5'd13,
    M_UNLINK    = 5'd14,
    M_UNLOCK    = 5'd15,
    M_MOVE      = 5'd16,
    M_MKCOL     = 5'd17
  } method_e;

  typedef logic [KeepLen-1:0][7:0]    name_view_t;
  typedef logic [VerbMaxLen-1:0][7:0] verb_text_t;

  typedef struct packed {
    logic             found;
    logic [CodeW-1:0] code;
  } match_res_t;

  // ascii upper case to lower case, everything else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // right-justified string literal to a first-char-at-index-0 array
  function automatic verb_text_t str_text(input logic [8*VerbMaxLen-1:0] s,
                                          input int unsigned len);
    verb_text_t t;
    t = '0;
    for (int unsigned i = 0; i < VerbMaxLen; i++) begin
      if (i < len) begin
        t[i] = s[8*(len-1-i) +: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [LenW-1:0] verb_len(input method_e m);
    logic [LenW-1:0] l;
    unique case (m)
      M_GET, M_PUT:                                         l = LenW'(3);
      M_POST, M_HEAD, M_COPY, M_LINK, M_LOCK, M_MOVE:       l = LenW'(4);
      M_PATCH, M_TRACE, M_MKCOL:                            l = LenW'(5);
      M_DELETE, M_UNLINK, M_UNLOCK:                         l = LenW'(6);
      M_OPTIONS, M_CONNECT:                                 l = LenW'(7);
      M_PROPFIND:                                           l = LenW'(8);
      M_PROPPATCH:                                          l = LenW'(9);
      default:                                              l = '0;
    endcase
    return l;
  endfunction

  function automatic verb_text_t verb_text(input method_e m);
    verb_text_t t;
    unique case (m)
      M_GET:       t = str_text("get", 3);
      M_POST:      t = str_text("post", 4);
      M_PUT:       t = str_text("put", 3);
      M_PATCH:     t = str_text("patch", 5);
      M_PROPFIND:  t = str_text("propfind", 8);
      M_PROPPATCH: t = str_text("proppatch", 9);
      M_OPTIONS:   t = str_text("options", 7);
      M_HEAD:      t = str_text("head", 4);
      M_DELETE:    t = str_text("delete", 6);
      M_TRACE:     t = str_text("trace", 5);
      M_CONNECT:   t = str_text("connect", 7);
      M_COPY:      t = str_text("copy", 4);
      M_LINK:      t = str_text("link", 4);
      M_LOCK:      t = str_text("lock", 4);
      M_UNLINK:    t = str_text("unlink", 6);
      M_UNLOCK:    t = str_text("unlock", 6);
      M_MOVE:      t = str_text("move", 4);
      M_MKCOL:     t = str_text("mkcol", 5);
      default:     t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/hmnm_match.sv =====
// ----------------------------------------------------------------------------
// hmnm_match
// prefix strip and exact compare of a collected name against the verb table
// ----------------------------------------------------------------------------
module hmnm_match (
  input  hmnm_pkg::name_view_t        name_i,  // collected lower-case name
  input  logic [hmnm_pkg::LenW-1:0]   len_i,   // name length, clipped above KeepLen
  output hmnm_pkg::match_res_t        res_o
);

  logic                               is_http;
  logic                               is_dav;
  logic [hmnm_pkg::LenW-1:0]          start;
  logic [hmnm_pkg::LenW-1:0]          rem;
  hmnm_pkg::verb_text_t               tail;
  logic [hmnm_pkg::VerbCount-1:0]     hit;
  logic [hmnm_pkg::CodeW-1:0]         code;

  // prefix detection on the leading bytes
  always_comb begin
    is_http = (len_i >= hmnm_pkg::LenW'(hmnm_pkg::HttpPreLen)) &&
              (name_i[0] == "h") && (name_i[1] == "t") && (name_i[2] == "t") &&
              (name_i[3] == "p") && (name_i[4] == "_");
    is_dav  = (len_i >= hmnm_pkg::LenW'(hmnm_pkg::DavPreLen)) &&
              (name_i[0] == "w") && (name_i[1] == "e") && (name_i[2] == "b") &&
              (name_i[3] == "d") && (name_i[4] == "a") && (name_i[5] == "v") &&
              (name_i[6] == "_");
    if (is_http) begin
      start = hmnm_pkg::LenW'(hmnm_pkg::HttpPreLen);
    end else if (is_dav) begin
      start = hmnm_pkg::LenW'(hmnm_pkg::DavPreLen);
    end else begin
      start = '0;
    end
    rem = len_i - start;
  end

  // align the remainder after the prefix
  always_comb begin
    for (int unsigned i = 0; i < hmnm_pkg::VerbMaxLen; i++) begin
      if (is_http) begin
        tail[i] = name_i[i + hmnm_pkg::HttpPreLen];
      end else if (is_dav) begin
        tail[i] = name_i[i + hmnm_pkg::DavPreLen];
      end else begin
        tail[i] = name_i[i];
      end
    end
  end

  // one comparator per verb, length must agree exactly
  always_comb begin
    hmnm_pkg::verb_text_t txt;
    logic [hmnm_pkg::LenW-1:0] vlen;
    logic same;
    for (int unsigned v = 0; v < hmnm_pkg::VerbCount; v++) begin
      txt  = hmnm_pkg::verb_text(hmnm_pkg::method_e'(v));
      vlen = hmnm_pkg::verb_len(hmnm_pkg::method_e'(v));
      same = (rem == vlen);
      for (int unsigned i = 0; i < hmnm_pkg::VerbMaxLen; i++) begin
        if ((hmnm_pkg::LenW'(i) < vlen) && (tail[i] != txt[i])) begin
          same = 1'b0;
        end
      end
      hit[v] = same;
    end
  end

  // verbs are distinct so at most one hit: or the codes together
  always_comb begin
    code = '0;
    for (int unsigned v = 0; v < hmnm_pkg::VerbCount; v++) begin
      if (hit[v]) begin
        code = code | hmnm_pkg::CodeW'(v);
      end
    end
    res_o.found = |hit;
    res_o.code  = code;
  end

endmodule

// ===== sv/http_method_name_matcher_core.sv =====
// ----------------------------------------------------------------------------
// http_method_name_matcher_core
// streaming recogniser of http and webdav method names
// ----------------------------------------------------------------------------
// A method name enters one character per beat, tlast on its final character.
// Letters are folded to lower case, a zero byte ends collection, and at most
// MAX_NAME_LEN characters count towards the name. On the tlast beat one
// leading "http_" or else "webdav_" is stripped and the rest is matched
// exactly against get, post, put, patch, propfind, proppatch, options, head,
// delete, trace, connect, copy, link, lock, unlink, unlock, move and mkcol
// (codes 0 to 17 in that order). One result beat follows each tlast beat,
// carrying found and the code (code 0 when not found). A beat is taken every
// cycle while the input does not stall; a tlast beat passes the input register,
// then the compare, and its result waits in the result register until taken.
// Input stalls only when a finished result is still waiting downstream.
// ----------------------------------------------------------------------------
`include "http_method_name_matcher_core_defines.svh"

module http_method_name_matcher_core #(
  parameter int unsigned MAX_NAME_LEN = 19
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] found, [5:1] method_code, [7:6] zero
);

  localparam int unsigned CntW = $clog2(MAX_NAME_LEN + 1);

  logic                        s1_valid_q;
  logic [7:0]                  s1_char_q;
  logic                        s1_last_q;
  logic                        s1_adv;
  logic                        out_free;

  hmnm_pkg::name_view_t        buf_q;
  hmnm_pkg::name_view_t        view;
  logic [CntW-1:0]             cnt_q;
  logic [CntW-1:0]             cnt_d;
  logic                        term_q;
  logic                        term_d;
  logic                        store;
  logic                        wr;
  logic                        nul;
  logic [7:0]                  fc;
  logic [hmnm_pkg::LenW-1:0]   len_clip;

  hmnm_pkg::match_res_t        match;
  logic                        out_valid_q;
  hmnm_pkg::match_res_t        out_res_q;

  // handshake: a non-last beat always drains, a last beat needs the result slot
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_char_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // character collection with the current beat folded in
  always_comb begin
    fc    = hmnm_pkg::fold_case(s1_char_q);
    nul   = !term_q && (s1_char_q == 8'h00);
    store = !term_q && (s1_char_q != 8'h00) && (cnt_q < CntW'(MAX_NAME_LEN));
    wr    = store && (cnt_q < CntW'(hmnm_pkg::KeepLen));
    for (int unsigned i = 0; i < hmnm_pkg::KeepLen; i++) begin
      view[i] = (wr && (cnt_q == CntW'(i))) ? fc : buf_q[i];
    end
    cnt_d    = cnt_q + CntW'(store);
    term_d   = term_q || nul;
    len_clip = (cnt_d > CntW'(hmnm_pkg::KeepLen)) ?
               hmnm_pkg::LenW'(hmnm_pkg::KeepLen + 1) : hmnm_pkg::LenW'(cnt_d);
  end

  // name buffer, entries past the count are never looked at
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      buf_q <= view;
    end
  end

  // count and terminator flag, cleared at the end of every name
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      term_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        cnt_q  <= '0;
        term_q <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        term_q <= term_d;
      end
    end
  end

  hmnm_match u_match (
    .name_i (view),
    .len_i  (len_clip),
    .res_o  (match)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_res_q <= match;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.code, out_res_q.found};

  // checks
  `HMNM_ASSERT(a_cnt_bound, cnt_q <= CntW'(MAX_NAME_LEN), "name count past its limit")
  `HMNM_ASSERT(a_name_clear, (s1_adv && s1_last_q) |=> (cnt_q == '0 && !term_q),
               "name state not cleared after last beat")
  `HMNM_ASSERT_NEVER(a_code_zero, out_valid_q && !out_res_q.found && out_res_q.code != '0,
                     "non-zero code on a miss")
  `HMNM_ASSERT_NEVER(a_code_range,
                     out_valid_q && out_res_q.code >= hmnm_pkg::CodeW'(hmnm_pkg::VerbCount),
                     "method code out of range")

endmodule
